// File: rtl/ps2sa_pkg.sv
// ============================================================================
// ps2sa_pkg
// Shared types, codes and translation tables for the set-1 scancode
// keyboard buffer.
// ============================================================================
`timescale 1ns / 1ps

package ps2sa_pkg;

    // Default ring depths.
    localparam int CHAR_DEPTH_DEF = 256;
    localparam int CODE_DEPTH_DEF = 64;

    // Number of entries in the translation tables.
    localparam logic [7:0] TABLE_LEN = 8'd58;

    // Request commands.
    localparam logic [1:0] CMD_SCAN     = 2'd0;
    localparam logic [1:0] CMD_POP_CHAR = 2'd1;
    localparam logic [1:0] CMD_POP_CODE = 2'd2;

    // Special scancodes.
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_BREAK_MASK   = 8'h80;

    // Request payload.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] scancode_in;
    } ps2sa_req_t;

    // Response payload.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_value;
        logic       dropped;
    } ps2sa_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } ps2sa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } ps2sa_ctrl_t;

    // Unshifted translation of a make code.
    function automatic logic [7:0] plain_char(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd2:  ch = 8'h31;
            6'd3:  ch = 8'h32;
            6'd4:  ch = 8'h33;
            6'd5:  ch = 8'h34;
            6'd6:  ch = 8'h35;
            6'd7:  ch = 8'h36;
            6'd8:  ch = 8'h37;
            6'd9:  ch = 8'h38;
            6'd10: ch = 8'h39;
            6'd11: ch = 8'h30;
            6'd12: ch = 8'h2D;
            6'd13: ch = 8'h3D;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h71;
            6'd17: ch = 8'h77;
            6'd18: ch = 8'h65;
            6'd19: ch = 8'h72;
            6'd20: ch = 8'h74;
            6'd21: ch = 8'h79;
            6'd22: ch = 8'h75;
            6'd23: ch = 8'h69;
            6'd24: ch = 8'h6F;
            6'd25: ch = 8'h70;
            6'd26: ch = 8'h5B;
            6'd27: ch = 8'h5D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h61;
            6'd31: ch = 8'h73;
            6'd32: ch = 8'h64;
            6'd33: ch = 8'h66;
            6'd34: ch = 8'h67;
            6'd35: ch = 8'h68;
            6'd36: ch = 8'h6A;
            6'd37: ch = 8'h6B;
            6'd38: ch = 8'h6C;
            6'd39: ch = 8'h3B;
            6'd40: ch = 8'h27;
            6'd41: ch = 8'h60;
            6'd43: ch = 8'h5C;
            6'd44: ch = 8'h7A;
            6'd45: ch = 8'h78;
            6'd46: ch = 8'h63;
            6'd47: ch = 8'h76;
            6'd48: ch = 8'h62;
            6'd49: ch = 8'h6E;
            6'd50: ch = 8'h6D;
            6'd51: ch = 8'h2C;
            6'd52: ch = 8'h2E;
            6'd53: ch = 8'h2F;
            6'd55: ch = 8'h2A;
            6'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted translation of a make code.
    function automatic logic [7:0] upper_char(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx)
            6'd2:  ch = 8'h21;
            6'd3:  ch = 8'h40;
            6'd4:  ch = 8'h23;
            6'd5:  ch = 8'h24;
            6'd6:  ch = 8'h25;
            6'd7:  ch = 8'h5E;
            6'd8:  ch = 8'h26;
            6'd9:  ch = 8'h2A;
            6'd10: ch = 8'h28;
            6'd11: ch = 8'h29;
            6'd12: ch = 8'h5F;
            6'd13: ch = 8'h2B;
            6'd14: ch = 8'h08;
            6'd15: ch = 8'h09;
            6'd16: ch = 8'h51;
            6'd17: ch = 8'h57;
            6'd18: ch = 8'h45;
            6'd19: ch = 8'h52;
            6'd20: ch = 8'h54;
            6'd21: ch = 8'h59;
            6'd22: ch = 8'h55;
            6'd23: ch = 8'h49;
            6'd24: ch = 8'h4F;
            6'd25: ch = 8'h50;
            6'd26: ch = 8'h7B;
            6'd27: ch = 8'h7D;
            6'd28: ch = 8'h0A;
            6'd30: ch = 8'h41;
            6'd31: ch = 8'h53;
            6'd32: ch = 8'h44;
            6'd33: ch = 8'h46;
            6'd34: ch = 8'h47;
            6'd35: ch = 8'h48;
            6'd36: ch = 8'h4A;
            6'd37: ch = 8'h4B;
            6'd38: ch = 8'h4C;
            6'd39: ch = 8'h3A;
            6'd40: ch = 8'h22;
            6'd41: ch = 8'h7E;
            6'd43: ch = 8'h7C;
            6'd44: ch = 8'h5A;
            6'd45: ch = 8'h58;
            6'd46: ch = 8'h43;
            6'd47: ch = 8'h56;
            6'd48: ch = 8'h42;
            6'd49: ch = 8'h4E;
            6'd50: ch = 8'h4D;
            6'd51: ch = 8'h3C;
            6'd52: ch = 8'h3E;
            6'd53: ch = 8'h3F;
            6'd55: ch = 8'h2A;
            6'd57: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/ps2_scancode_to_ascii_fifo.sv
// ============================================================================
// ps2_scancode_to_ascii_fifo
// Set-1 keyboard scancode front end with a character ring and a raw
// scancode ring.
// ============================================================================
// Usage:
//   The request channel (req_valid, req_ready, req) carries a command and a
//   scancode byte. Command scan feeds a set-1 scancode: shift codes set or
//   clear the shift flag, caps lock toggles, other make codes go to the raw
//   ring and, when they have an ASCII translation, to the character ring.
//   The pop commands return the oldest byte of the character or raw ring.
//   The response channel (rsp_valid, rsp_ready, rsp) returns one result per
//   request: out_valid and out_value for pops, dropped when a push found its
//   ring full. Each ring holds at most its depth minus one bytes.
//   Each transaction passes through the capture, execute and publish
//   steps of the controller around the registered RAM read port; a new
//   request is accepted only once the previous response is published.
//   Reset clears the flags and ring pointers at once; ring contents are not
//   cleared. While the receiver stalls, the response is held and the next
//   request waits in the publish step, so requests back up.
// ============================================================================
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_fifo
    import ps2sa_pkg::*;
#(
    parameter int CHAR_DEPTH = CHAR_DEPTH_DEF,
    parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ps2sa_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output ps2sa_rsp_t rsp
);

    ps2sa_ctrl_t ctrl;

    // Transaction sequencer.
    ps2sa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    // Flags, translation and rings.
    ps2sa_dp #(
        .CHAR_DEPTH (CHAR_DEPTH),
        .CODE_DEPTH (CODE_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// File: rtl/ps2sa_ram.sv
// ============================================================================
// ps2sa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
`timescale 1ns / 1ps

module ps2sa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/ps2sa_ctrl.sv
// ============================================================================
// ps2sa_ctrl
// Controller for the keyboard buffer: sequences capture, execution and
// publication of one transaction and owns the response valid flag.
// ============================================================================
`timescale 1ns / 1ps

module ps2sa_ctrl
    import ps2sa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output ps2sa_ctrl_t ctrl
);

    ps2sa_state_t state_reg;
    ps2sa_state_t state_next;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    logic         slot_free;

    // The response register can take a new value when empty or being drained.
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        req_ready    = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        ctrl.publish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
            end
            ST_EXEC:
            begin
                ctrl.execute = 1'b1;
            end
            ST_FINISH:
            begin
                ctrl.publish = slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Response valid flag: set on publish, cleared once taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/ps2sa_dp.sv
// ============================================================================
// ps2sa_dp
// Datapath for the keyboard buffer: modifier flags, scancode translation,
// the character and scancode rings and the response register.
// ============================================================================
`timescale 1ns / 1ps

module ps2sa_dp
    import ps2sa_pkg::*;
#(
    parameter int CHAR_DEPTH = CHAR_DEPTH_DEF,
    parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ps2sa_ctrl_t ctrl,
    input  ps2sa_req_t  req,
    output ps2sa_rsp_t  rsp
);

    localparam int CHAR_AW = $clog2(CHAR_DEPTH);
    localparam int CODE_AW = $clog2(CODE_DEPTH);
    localparam logic [CHAR_AW-1:0] CHAR_LAST = CHAR_AW'(CHAR_DEPTH - 1);
    localparam logic [CODE_AW-1:0] CODE_LAST = CODE_AW'(CODE_DEPTH - 1);

    ps2sa_req_t         req_reg;
    ps2sa_rsp_t         rsp_reg;
    logic               shift_reg;
    logic               shift_next;
    logic               caps_reg;
    logic               caps_next;
    logic [CHAR_AW-1:0] char_rd_reg;
    logic [CHAR_AW-1:0] char_rd_next;
    logic [CHAR_AW-1:0] char_wr_reg;
    logic [CHAR_AW-1:0] char_wr_next;
    logic [CODE_AW-1:0] code_rd_reg;
    logic [CODE_AW-1:0] code_rd_next;
    logic [CODE_AW-1:0] code_wr_reg;
    logic [CODE_AW-1:0] code_wr_next;
    logic               hit_reg;
    logic               hit_next;
    logic               sel_code_reg;
    logic               sel_code_next;
    logic               drop_reg;
    logic               drop_next;

    logic [CHAR_AW-1:0] char_wr_inc;
    logic [CHAR_AW-1:0] char_rd_inc;
    logic [CODE_AW-1:0] code_wr_inc;
    logic [CODE_AW-1:0] code_rd_inc;
    logic               char_full;
    logic               char_empty;
    logic               code_full;
    logic               code_empty;
    logic [7:0]         sc;
    logic               is_make;
    logic               in_table;
    logic [7:0]         ch;
    logic               char_we;
    logic               code_we;
    logic               char_re;
    logic               code_re;
    logic [7:0]         char_rdata;
    logic [7:0]         code_rdata;

    // Ring pointer increments with wrap at the depth.
    assign char_wr_inc = (char_wr_reg == CHAR_LAST) ? '0 : char_wr_reg + 1'b1;
    assign char_rd_inc = (char_rd_reg == CHAR_LAST) ? '0 : char_rd_reg + 1'b1;
    assign code_wr_inc = (code_wr_reg == CODE_LAST) ? '0 : code_wr_reg + 1'b1;
    assign code_rd_inc = (code_rd_reg == CODE_LAST) ? '0 : code_rd_reg + 1'b1;

    // Each ring keeps one slot free to tell full from empty.
    assign char_full  = (char_wr_inc == char_rd_reg);
    assign code_full  = (code_wr_inc == code_rd_reg);
    assign char_empty = (char_rd_reg == char_wr_reg);
    assign code_empty = (code_rd_reg == code_wr_reg);

    // Scancode classification and translation.
    assign sc       = req_reg.scancode_in;
    assign in_table = (sc < TABLE_LEN);
    assign ch       = !in_table ? 8'h00 :
                      (shift_reg ^ caps_reg) ? upper_char(sc[5:0]) : plain_char(sc[5:0]);

    // Execution of the captured transaction.
    always_comb
    begin
        shift_next    = shift_reg;
        caps_next     = caps_reg;
        is_make       = 1'b0;
        code_we       = 1'b0;
        char_we       = 1'b0;
        code_re       = 1'b0;
        char_re       = 1'b0;
        drop_next     = 1'b0;
        hit_next      = 1'b0;
        sel_code_next = 1'b0;
        case (req_reg.command)
            CMD_SCAN:
            begin
                if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE)
                begin
                    shift_next = 1'b1;
                end
                else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK)
                begin
                    shift_next = 1'b0;
                end
                else if (sc == SC_CAPS_MAKE)
                begin
                    caps_next = !caps_reg;
                end
                else if ((sc & SC_BREAK_MASK) == 8'h00)
                begin
                    is_make = 1'b1;
                end
                code_we   = is_make && !code_full;
                char_we   = is_make && (ch != 8'h00) && !char_full;
                drop_next = is_make && (code_full || ((ch != 8'h00) && char_full));
            end
            CMD_POP_CHAR:
            begin
                char_re  = !char_empty;
                hit_next = !char_empty;
            end
            CMD_POP_CODE:
            begin
                code_re       = !code_empty;
                hit_next      = !code_empty;
                sel_code_next = 1'b1;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    // Pointer updates, gated by the execute step.
    assign char_wr_next = (ctrl.execute && char_we) ? char_wr_inc : char_wr_reg;
    assign code_wr_next = (ctrl.execute && code_we) ? code_wr_inc : code_wr_reg;
    assign char_rd_next = (ctrl.execute && char_re) ? char_rd_inc : char_rd_reg;
    assign code_rd_next = (ctrl.execute && code_re) ? code_rd_inc : code_rd_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= 1'b0;
            caps_reg     <= 1'b0;
            char_rd_reg  <= '0;
            char_wr_reg  <= '0;
            code_rd_reg  <= '0;
            code_wr_reg  <= '0;
        end
        else
        begin
            if (ctrl.execute)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
            end
            char_rd_reg <= char_rd_next;
            char_wr_reg <= char_wr_next;
            code_rd_reg <= code_rd_next;
            code_wr_reg <= code_wr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= req;
        end
        if (ctrl.execute)
        begin
            hit_reg      <= hit_next;
            sel_code_reg <= sel_code_next;
            drop_reg     <= drop_next;
        end
        if (ctrl.publish)
        begin
            rsp_reg.out_valid <= hit_reg;
            rsp_reg.out_value <= !hit_reg ? 8'h00 :
                                 sel_code_reg ? code_rdata : char_rdata;
            rsp_reg.dropped   <= drop_reg;
        end
    end

    assign rsp = rsp_reg;

    // Character ring storage.
    ps2sa_ram #(
        .WIDTH (8),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (ctrl.execute && char_we),
        .wr_addr (char_wr_reg),
        .wr_data (ch),
        .rd_en   (ctrl.execute && char_re),
        .rd_addr (char_rd_reg),
        .rd_data (char_rdata)
    );

    // Raw scancode ring storage.
    ps2sa_ram #(
        .WIDTH (8),
        .DEPTH (CODE_DEPTH)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (ctrl.execute && code_we),
        .wr_addr (code_wr_reg),
        .wr_data (sc),
        .rd_en   (ctrl.execute && code_re),
        .rd_addr (code_rd_reg),
        .rd_data (code_rdata)
    );

endmodule
